// ----- rtl/core/pdcf_pkg.sv -----
`default_nettype none

package pdcf_pkg;

    localparam int unsigned RING_DEPTH_DEF = 16;

    localparam logic [7:0]  BYTE_CR   = 8'h0D;
    localparam logic [7:0]  BYTE_LF   = 8'h0A;
    localparam logic [7:0]  BYTE_NUL  = 8'h00;
    localparam logic [31:0] OFF_MULT  = 32'd31;   // weight per byte offset
    localparam logic [2:0]  SEP_LEN   = 3'd4;     // CR LF CR LF

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic        duplicate;
        logic [31:0] page_checksum;
    } t_out_req;

    // CR LF CR LF matcher step, returns progress 0..4
    function automatic logic [2:0] match_next(input logic [1:0] prog,
                                              input logic [7:0] b);
        logic [2:0] res;
        res = 3'd0;
        if (!prog[0]) begin
            if (b == BYTE_CR) begin
                res = {1'b0, prog} + 3'd1;
            end
        end else if (b == BYTE_LF) begin
            res = {1'b0, prog} + 3'd1;
        end else if (b == BYTE_CR) begin
            res = 3'd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/page_duplicate_checksum_filter.sv -----
// A last byte passes the input register and then the result register before its result shows.
// Throughput: one byte per cycle unless a last byte is held; the whole per-byte update and the parallel
// compare against all ring entries sit between the input and result registers.
// A last byte waits in the input register only while the result register is full and stalled.
// Reset (synchronous, active low) clears the ring to zero, the ring pointer and all page state.
`default_nettype none

module page_duplicate_checksum_filter #(
    parameter int unsigned RING_DEPTH = pdcf_pkg::RING_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire pdcf_pkg::t_in_req  i_in_req,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output pdcf_pkg::t_out_req      o_out_req,
    input  wire logic               i_out_stall
);

    localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    // input register
    logic               r_in_valid;
    pdcf_pkg::t_in_req  r_in_req;

    // page state
    logic [31:0] r_whole_sum, n_whole_sum;
    logic [31:0] r_body_sum,  n_body_sum;
    logic [1:0]  r_page_phase, n_page_phase;   // page offset mod 4
    logic [31:0] r_page_wt,   n_page_wt;       // page offset * 31
    logic [31:0] r_body_off,  n_body_off;
    logic [31:0] r_body_wt,   n_body_wt;       // body offset * 31
    logic [1:0]  r_sep_prog,  n_sep_prog;
    logic        r_sep_seen,  n_sep_seen;
    logic        r_text_term, n_text_term;
    logic        r_body_valid, n_body_valid;

    // ring
    logic [31:0]      r_ring [RING_DEPTH];
    logic [PTR_W-1:0] r_ptr;

    // result register
    logic               r_out_valid;
    pdcf_pkg::t_out_req r_out_req;

    logic        out_free, advance, do_step, do_last, dup;
    logic [31:0] sext, crc;
    logic [2:0]  sep_next;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = !r_in_req.last_byte || out_free;
    assign do_step    = r_in_valid && advance;
    assign do_last    = do_step && r_in_req.last_byte;
    assign o_in_stall = r_in_valid && !advance;
    assign sext       = {{24{r_in_req.data_byte[7]}}, r_in_req.data_byte};
    assign sep_next   = pdcf_pkg::match_next(r_sep_prog, r_in_req.data_byte);

    always_comb begin
        n_whole_sum  = r_whole_sum;
        n_body_sum   = r_body_sum;
        n_body_off   = r_body_off;
        n_body_wt    = r_body_wt;
        n_sep_prog   = r_sep_prog;
        n_sep_seen   = r_sep_seen;
        n_text_term  = r_text_term;
        n_body_valid = r_body_valid;
        n_page_phase = r_page_phase + 2'd1;
        n_page_wt    = r_page_wt + pdcf_pkg::OFF_MULT;

        if (r_page_phase == 2'd0) begin
            n_whole_sum = r_whole_sum + sext + r_page_wt;
        end

        if (r_sep_seen) begin
            if (r_body_off == 32'd0) begin
                n_body_valid = (r_in_req.data_byte != pdcf_pkg::BYTE_NUL);
            end
            if (r_body_off[1:0] == 2'd0) begin
                n_body_sum = r_body_sum + sext + r_body_wt;
            end
            n_body_off = r_body_off + 32'd1;
            n_body_wt  = r_body_wt + pdcf_pkg::OFF_MULT;
        end else if (!r_text_term) begin
            if (r_in_req.data_byte == pdcf_pkg::BYTE_NUL) begin
                n_text_term = 1'b1;
                n_sep_prog  = 2'd0;
            end else if (sep_next == pdcf_pkg::SEP_LEN) begin
                n_sep_seen = 1'b1;
                n_sep_prog = 2'd0;
            end else begin
                n_sep_prog = sep_next[1:0];
            end
        end
    end

    assign crc = n_body_valid ? n_body_sum : n_whole_sum;

    always_comb begin
        dup = 1'b0;
        for (int k = 0; k < RING_DEPTH; k++) begin
            if (r_ring[k] == crc) begin
                dup = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_req <= i_in_req;
        end
        if (do_last) begin
            r_out_req.duplicate     <= dup;
            r_out_req.page_checksum <= crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_whole_sum  <= '0;
            r_body_sum   <= '0;
            r_page_phase <= '0;
            r_page_wt    <= '0;
            r_body_off   <= '0;
            r_body_wt    <= '0;
            r_sep_prog   <= '0;
            r_sep_seen   <= 1'b0;
            r_text_term  <= 1'b0;
            r_body_valid <= 1'b0;
            r_ptr        <= '0;
            for (int k = 0; k < RING_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end

            if (do_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (do_last) begin
                // new page starts clean; ring and pointer survive
                r_whole_sum  <= '0;
                r_body_sum   <= '0;
                r_page_phase <= '0;
                r_page_wt    <= '0;
                r_body_off   <= '0;
                r_body_wt    <= '0;
                r_sep_prog   <= '0;
                r_sep_seen   <= 1'b0;
                r_text_term  <= 1'b0;
                r_body_valid <= 1'b0;
                if (!dup) begin
                    r_ring[r_ptr] <= crc;
                    r_ptr <= (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);
                end
            end else if (do_step) begin
                r_whole_sum  <= n_whole_sum;
                r_body_sum   <= n_body_sum;
                r_page_phase <= n_page_phase;
                r_page_wt    <= n_page_wt;
                r_body_off   <= n_body_off;
                r_body_wt    <= n_body_wt;
                r_sep_prog   <= n_sep_prog;
                r_sep_seen   <= n_sep_seen;
                r_text_term  <= n_text_term;
                r_body_valid <= n_body_valid;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_LAST)
        else $error("ring pointer beyond ring depth");

    a_dup_keeps_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_last && dup) |=> $stable(r_ptr))
        else $error("ring pointer moved on a duplicate");

    a_sep_term_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sep_seen && r_text_term))
        else $error("separator and terminator both recorded");

    a_page_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_last |=> (r_body_off == 32'd0 && !r_sep_seen && r_page_phase == 2'd0
                     && r_whole_sum == 32'd0))
        else $error("page state not cleared after last byte");

    a_last_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_last |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
